### rtl/lms_pkg.sv
// Package with request codes, state encodings and timing constants of the lock motor sequencer.
package lms_pkg;

   localparam logic [2:0] REQ_TICK  = 3'd0;
   localparam logic [2:0] REQ_OPEN  = 3'd1;
   localparam logic [2:0] REQ_CLOSE = 3'd2;
   localparam logic [2:0] REQ_PROC  = 3'd3;
   localparam logic [2:0] REQ_DOOR  = 3'd4;

   localparam logic [2:0] MODE_IDLE   = 3'd0;
   localparam logic [2:0] MODE_LOCK   = 3'd1;
   localparam logic [2:0] MODE_UNLOCK = 3'd2;
   localparam logic [2:0] MODE_WAIT   = 3'd3;

   localparam logic [3:0] SS_IN  = 4'd0;
   localparam logic [3:0] SS_S1  = 4'd1;
   localparam logic [3:0] SS_S2  = 4'd2;
   localparam logic [3:0] SS_S3  = 4'd3;
   localparam logic [3:0] SS_S4  = 4'd4;
   localparam logic [3:0] SS_S5  = 4'd5;
   localparam logic [3:0] SS_S6  = 4'd6;
   localparam logic [3:0] SS_S7  = 4'd7;
   localparam logic [3:0] SS_OK  = 4'd8;
   localparam logic [3:0] SS_END = 4'd9;
   localparam logic [3:0] SS_ERR = 4'd10;

   localparam logic [1:0] POS_MID    = 2'd0;
   localparam logic [1:0] POS_LOCK   = 2'd1;
   localparam logic [1:0] POS_UNLOCK = 2'd2;

   localparam logic [1:0] TRACK_IDLE     = 2'd0;
   localparam logic [1:0] TRACK_OPEN     = 2'd1;
   localparam logic [1:0] TRACK_OPENLOCK = 2'd2;

   localparam logic [1:0] DRV_STOP = 2'd0;
   localparam logic [1:0] DRV_ONE  = 2'd1;
   localparam logic [1:0] DRV_ZERO = 2'd2;

   localparam logic [1:0] CMP_NONE  = 2'd0;
   localparam logic [1:0] CMP_THERE = 2'd1;
   localparam logic [1:0] CMP_DONE  = 2'd2;
   localparam logic [1:0] CMP_ERR   = 2'd3;

   localparam logic [2:0] CSR_ON_LEVEL  = 3'd0;
   localparam logic [2:0] CSR_OFF_LEVEL = 3'd1;
   localparam logic [2:0] CSR_CEILING   = 3'd2;
   localparam logic [2:0] CSR_FLOOR     = 3'd3;
   localparam logic [2:0] CSR_AUTO_EN   = 3'd4;
   localparam logic [2:0] CSR_DOOR_EN   = 3'd5;
   localparam logic [2:0] CSR_AUTO_TICK = 3'd6;
   localparam logic [2:0] CSR_TEST_MODE = 3'd7;

   localparam logic [6:0] T_WORK   = 7'd78;
   localparam logic [6:0] T_PAUSE  = 7'd15;
   localparam logic [6:0] T_BACK   = 7'd7;
   localparam logic [6:0] T_TRAVEL = 7'd23;

   localparam logic [7:0] PHASE_RESTART = 8'hff;
   localparam logic [7:0] PHASE_WRAP    = 8'hfe;

endpackage

### rtl/lock_motor_sequencer.sv
// Top level of the lock motor sequencer: state update per request and registered result.
//
//  channel | ports                      | payload
//  --------+----------------------------+------------------------------------------
//  request | req_tvalid/tready/tdata    | req_type, col1_low, col2_low, reversal,
//          |                            | door_sw_low, door_open, side_left_sample
//  result  | rsp_tvalid/tready/tdata    | motor_drive .. sense_drive_high
//  config  | csr_we, csr_index, csr_data| eight registers
//
// Each request is applied to the state in the cycle it is accepted and its result
// lands in the output register at the same edge, so one request per cycle is taken.
// The request side is ready whenever the output register is empty or is being drained.
// Reset is synchronous and active high; it returns all registers but the result data
// to their defaults. A stalled result holds, and new requests wait until it is taken.
module lock_motor_sequencer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // Fields from bit 0: req_type[2:0], col1_low, col2_low, reversal_level,
   // door_sw_low, door_open, side_left_sample, zero pad.
   input  logic [15:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // Fields from bit 0: motor_drive[1:0], position[3:2], busy_res, completion[6:5],
   // start_beep, auto_lock_request, door_state[10:9], sense_drive_high, zero pad.
   output logic [15:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_data
);

   // Configuration registers.
   logic [7:0] on_lvl_ff, off_lvl_ff, ceil_ff, floor_ff, al_ticks_ff;
   logic       al_en_ff, door_en_ff, test_ff;

   // Sequencer state.
   logic [2:0] mode_ff, mode_in;
   logic [3:0] sub_ff, sub_in;
   logic [6:0] stmr_ff, stmr_in;
   logic [7:0] atmr_ff, atmr_in;
   logic [7:0] phase_ff, phase_in;
   logic [7:0] lvl_ff, lvl_in, vert_ff, vert_in, back_ff, back_in;
   logic [1:0] dcnt_ff, dcnt_in;
   logic [1:0] track_ff, track_in;
   logic [1:0] pos_ff, pos_in;
   logic       trav_ff, trav_in, left_ff, left_in;
   logic [1:0] drv_ff, drv_in;
   logic       sense_ff, sense_in;

   logic        out_valid_ff;
   logic [15:0] out_data_ff, out_data_in;

   logic       accept;
   logic [2:0] rtype;
   logic       c1, c2, rev, dsw, dopen, sleft;
   logic [1:0] cmp;
   logic       start, areq;

   assign req_tready = !out_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   assign rtype = req_tdata[2:0];
   assign c1    = req_tdata[3];
   assign c2    = req_tdata[4];
   assign rev   = req_tdata[5];
   assign dsw   = req_tdata[6];
   assign dopen = req_tdata[7];
   assign sleft = req_tdata[8];

   function automatic logic [7:0] cnt_step(input logic [7:0] c, input logic up,
                                           input logic [7:0] ceil_v,
                                           input logic [7:0] flr_v);
      logic [7:0] r;
      r = c;
      if (up) begin
         if (c < ceil_v) r = c + 8'd1;
      end else begin
         if (c > flr_v) r = c - 8'd1;
      end
      return r;
   endfunction

   always_comb begin
      logic       lvl_on, vert_on, fwd, unl, there, hit, seq;
      logic [7:0] l2, v2;
      mode_in = mode_ff; sub_in = sub_ff; stmr_in = stmr_ff; atmr_in = atmr_ff;
      phase_in = phase_ff; lvl_in = lvl_ff; vert_in = vert_ff; back_in = back_ff;
      dcnt_in = dcnt_ff; track_in = track_ff; pos_in = pos_ff; trav_in = trav_ff;
      left_in = left_ff; drv_in = drv_ff; sense_in = sense_ff;
      cmp = lms_pkg::CMP_NONE; start = 1'b0; areq = 1'b0;
      lvl_on = 1'b0; vert_on = 1'b0; fwd = 1'b0; unl = 1'b0; there = 1'b0; hit = 1'b0;
      seq = 1'b0; l2 = lvl_ff; v2 = vert_ff;
      case (rtype)
         lms_pkg::REQ_TICK: begin
            if (stmr_ff != 7'd0) stmr_in = stmr_ff - 7'd1;
            if (atmr_ff != 8'd0) begin
               atmr_in = atmr_ff - 8'd1;
               if (atmr_ff == 8'd1) areq = 1'b1;
            end
            if (phase_ff == lms_pkg::PHASE_RESTART) begin
               sense_in = 1'b1;
               phase_in = phase_ff + 8'd1;
            end else if (mode_ff != lms_pkg::MODE_IDLE) begin
               sense_in = 1'b1;
               phase_in = 8'd2;
            end else if (phase_ff == 8'd4) begin
               sense_in = 1'b0;
               phase_in = 8'd5;
            end else if (phase_ff > 8'd8) begin
               phase_in = lms_pkg::PHASE_RESTART;
            end else begin
               phase_in = phase_ff + 8'd1;
            end
         end
         lms_pkg::REQ_OPEN: begin
            if (mode_ff == lms_pkg::MODE_IDLE) begin
               mode_in = lms_pkg::MODE_UNLOCK; sub_in = lms_pkg::SS_IN; left_in = sleft;
            end
         end
         lms_pkg::REQ_CLOSE: begin
            if (mode_ff == lms_pkg::MODE_IDLE || mode_ff == lms_pkg::MODE_WAIT) begin
               mode_in = lms_pkg::MODE_LOCK; track_in = lms_pkg::TRACK_IDLE;
               sub_in = lms_pkg::SS_IN; left_in = sleft;
            end
         end
         lms_pkg::REQ_PROC: begin
            // Position sampling during the detect window.
            if (phase_ff > 8'd0 && phase_ff < 8'd4) begin
               sense_in = 1'b1;
               l2 = cnt_step(lvl_ff, c1, ceil_ff, floor_ff);
               v2 = cnt_step(vert_ff, c2, ceil_ff, floor_ff);
               lvl_in = l2; vert_in = v2;
               if (left_ff) begin
                  if (l2 > on_lvl_ff) begin
                     pos_in = lms_pkg::POS_UNLOCK;
                     if (door_en_ff && track_ff == lms_pkg::TRACK_IDLE)
                        track_in = lms_pkg::TRACK_OPENLOCK;
                  end else if (v2 > on_lvl_ff) pos_in = lms_pkg::POS_LOCK;
                  else pos_in = lms_pkg::POS_MID;
               end else begin
                  if (l2 > on_lvl_ff) pos_in = lms_pkg::POS_LOCK;
                  else if (v2 > on_lvl_ff) pos_in = lms_pkg::POS_UNLOCK;
                  else pos_in = lms_pkg::POS_MID;
               end
            end
            lvl_on  = l2 > on_lvl_ff;
            vert_on = v2 > on_lvl_ff;
            unl = (mode_ff == lms_pkg::MODE_UNLOCK);
            fwd = (unl == left_ff);
            seq = (mode_ff == lms_pkg::MODE_LOCK) || unl;
            if (seq) begin
               case (sub_ff)
                  lms_pkg::SS_IN: begin
                     there = fwd ? lvl_on : vert_on;
                     if (there) sub_in = lms_pkg::SS_OK;
                     else begin
                        drv_in = fwd ? lms_pkg::DRV_ONE : lms_pkg::DRV_ZERO;
                        sub_in = lms_pkg::SS_S1; stmr_in = lms_pkg::T_WORK; start = 1'b1;
                     end
                  end
                  lms_pkg::SS_S1: begin
                     if (stmr_ff == 7'd0) begin
                        drv_in = lms_pkg::DRV_STOP; sub_in = lms_pkg::SS_ERR;
                     end else begin
                        hit = fwd ? (lvl_on || c1) : (vert_on || c2);
                        if (hit) begin
                           sub_in = lms_pkg::SS_S2;
                           stmr_in = (!unl && !left_ff) ? 7'd2 : 7'd1;
                        end
                     end
                  end
                  lms_pkg::SS_S2: begin
                     hit = unl ? (left_ff ? c1 : c2) : (c1 || c2);
                     if (hit || stmr_ff == 7'd0) begin
                        drv_in = lms_pkg::DRV_STOP; stmr_in = lms_pkg::T_PAUSE;
                        sub_in = lms_pkg::SS_S3;
                     end
                  end
                  lms_pkg::SS_S3: begin
                     if (stmr_ff == 7'd0) begin
                        trav_in = rev;
                        drv_in = fwd ? lms_pkg::DRV_ZERO : lms_pkg::DRV_ONE;
                        stmr_in = lms_pkg::T_BACK; sub_in = lms_pkg::SS_S4;
                     end
                  end
                  lms_pkg::SS_S4: begin
                     if (trav_ff != rev || stmr_ff == 7'd0) begin
                        stmr_in = lms_pkg::T_TRAVEL; sub_in = lms_pkg::SS_S5;
                     end
                  end
                  lms_pkg::SS_S5: begin
                     if (!unl) back_in = cnt_step(back_ff, !rev, ceil_ff, floor_ff);
                     if (stmr_ff == 7'd0) begin
                        drv_in = lms_pkg::DRV_STOP; sub_in = lms_pkg::SS_ERR;
                     end else if (back_in < off_lvl_ff || trav_ff != rev) begin
                        stmr_in = 7'd0; sub_in = lms_pkg::SS_S6;
                     end
                  end
                  lms_pkg::SS_S6: begin
                     if (stmr_ff == 7'd0) begin
                        drv_in = fwd ? lms_pkg::DRV_ZERO : lms_pkg::DRV_ONE;
                        sub_in = lms_pkg::SS_S7;
                        if (unl) stmr_in = left_ff ? 7'd4 : 7'd6;
                        else stmr_in = left_ff ? 7'd5 : 7'd4;
                     end
                  end
                  lms_pkg::SS_S7: begin
                     if (stmr_ff == 7'd0) begin
                        drv_in = lms_pkg::DRV_STOP; sub_in = lms_pkg::SS_END;
                     end
                  end
                  lms_pkg::SS_OK, lms_pkg::SS_END, lms_pkg::SS_ERR: ;
                  default: begin
                     drv_in = lms_pkg::DRV_STOP; sub_in = lms_pkg::SS_ERR;
                  end
               endcase
               if (sub_in == lms_pkg::SS_OK) begin
                  mode_in = lms_pkg::MODE_IDLE; cmp = lms_pkg::CMP_THERE;
                  if (unl && al_en_ff) atmr_in = al_ticks_ff;
               end else if (sub_in == lms_pkg::SS_ERR) begin
                  mode_in = lms_pkg::MODE_IDLE; cmp = lms_pkg::CMP_ERR;
               end else if (sub_in == lms_pkg::SS_END) begin
                  mode_in = lms_pkg::MODE_IDLE; cmp = lms_pkg::CMP_DONE;
                  if (unl && !test_ff) begin
                     if (al_en_ff) atmr_in = al_ticks_ff;
                     if (door_en_ff) begin
                        stmr_in = lms_pkg::T_WORK; mode_in = lms_pkg::MODE_WAIT;
                     end
                  end
               end
            end else if (mode_ff == lms_pkg::MODE_WAIT) begin
               if (dopen) begin
                  track_in = lms_pkg::TRACK_OPEN; mode_in = lms_pkg::MODE_IDLE;
               end else if (stmr_ff == 7'd0) begin
                  mode_in = lms_pkg::MODE_IDLE; track_in = lms_pkg::TRACK_OPENLOCK;
               end
            end else if (mode_ff != lms_pkg::MODE_IDLE) begin
               mode_in = lms_pkg::MODE_IDLE;
            end
         end
         lms_pkg::REQ_DOOR: begin
            if (dsw) begin
               if (dcnt_ff != 2'd3) begin
                  dcnt_in = dcnt_ff + 2'd1;
                  if (dcnt_ff == 2'd2 && track_ff == lms_pkg::TRACK_OPEN && door_en_ff
                      && pos_ff != lms_pkg::POS_LOCK) areq = 1'b1;
               end
            end else if (dcnt_ff != 2'd0) begin
               dcnt_in = dcnt_ff - 2'd1;
               if (dcnt_ff == 2'd1 && track_ff == lms_pkg::TRACK_OPENLOCK)
                  track_in = lms_pkg::TRACK_OPEN;
            end
         end
         default: ;
      endcase
      out_data_in = {4'd0, sense_in, track_in, areq, start, cmp,
                     (mode_in != lms_pkg::MODE_IDLE), pos_in, drv_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         on_lvl_ff <= 8'd3; off_lvl_ff <= 8'd2; ceil_ff <= 8'd5; floor_ff <= 8'd0;
         al_en_ff <= 1'b0; door_en_ff <= 1'b0; al_ticks_ff <= 8'd78; test_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            lms_pkg::CSR_ON_LEVEL:  on_lvl_ff   <= csr_data;
            lms_pkg::CSR_OFF_LEVEL: off_lvl_ff  <= csr_data;
            lms_pkg::CSR_CEILING:   ceil_ff     <= csr_data;
            lms_pkg::CSR_FLOOR:     floor_ff    <= csr_data;
            lms_pkg::CSR_AUTO_EN:   al_en_ff    <= csr_data[0];
            lms_pkg::CSR_DOOR_EN:   door_en_ff  <= csr_data[0];
            lms_pkg::CSR_AUTO_TICK: al_ticks_ff <= csr_data;
            lms_pkg::CSR_TEST_MODE: test_ff     <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= lms_pkg::MODE_IDLE; sub_ff <= lms_pkg::SS_IN; stmr_ff <= 7'd0;
         atmr_ff <= 8'd0; phase_ff <= lms_pkg::PHASE_RESTART; lvl_ff <= 8'd0;
         vert_ff <= 8'd0; back_ff <= 8'd0; dcnt_ff <= 2'd0;
         track_ff <= lms_pkg::TRACK_IDLE; pos_ff <= lms_pkg::POS_MID; trav_ff <= 1'b0;
         left_ff <= 1'b0; drv_ff <= lms_pkg::DRV_STOP; sense_ff <= 1'b1;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            mode_ff <= mode_in; sub_ff <= sub_in; stmr_ff <= stmr_in; atmr_ff <= atmr_in;
            phase_ff <= phase_in; lvl_ff <= lvl_in; vert_ff <= vert_in; back_ff <= back_in;
            dcnt_ff <= dcnt_in; track_ff <= track_in; pos_ff <= pos_in; trav_ff <= trav_in;
            left_ff <= left_in; drv_ff <= drv_in; sense_ff <= sense_in;
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) out_data_ff <= out_data_in;
   end

endmodule

### tb/sv/lock_motor_sequencer_test.sv
// Self-checking testbench of the lock motor sequencer with its own bit-true prediction.
module lock_motor_sequencer_test;

   // The run is stopped here if the block hangs.
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [7:0]  csr_data = '0;

   lock_motor_sequencer i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Shadow copy of the configuration registers.
   logic [7:0] on_level, off_level, ceiling_lvl, floor_lvl, auto_ticks;
   logic       auto_en, door_en, test_mode;

   // Shadow copy of the sequencer state.
   logic [2:0] mode;
   logic [3:0] step;
   logic [6:0] step_tmr;
   logic [7:0] auto_tmr, phase, level_cnt, vert_cnt, back_cnt;
   logic [1:0] door_cnt, track, bolt, drive;
   logic       travel_prev, left_side, sense_high;
   logic [1:0] done_code;
   logic       start_pulse, relock_pulse;

   // Expected results in the order the requests were accepted.
   logic [11:0] expected_results[$];

   int errors = 0;
   int cycles = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   logic hold_active = 1'b0;
   event hold_go;

   // All of the prediction works on the 9-bit request:
   // type[2:0], col1_low, col2_low, reversal, door_sw_low, door_open, side_left_sample.

   task automatic model_reset();
      on_level = 8'd3; off_level = 8'd2; ceiling_lvl = 8'd5; floor_lvl = 8'd0;
      auto_en = 1'b0; door_en = 1'b0; auto_ticks = 8'd78; test_mode = 1'b0;
      mode = lms_pkg::MODE_IDLE; step = lms_pkg::SS_IN; step_tmr = '0; auto_tmr = '0;
      phase = lms_pkg::PHASE_RESTART; level_cnt = '0; vert_cnt = '0; back_cnt = '0;
      door_cnt = '0; track = lms_pkg::TRACK_IDLE; bolt = lms_pkg::POS_MID;
      travel_prev = 1'b0;
      left_side = 1'b0; drive = lms_pkg::DRV_STOP; sense_high = 1'b1;
   endtask

   function automatic logic [7:0] saturate_step(logic [7:0] c, logic up);
      if (up) return (c < ceiling_lvl) ? c + 8'd1 : c;
      return (c > floor_lvl) ? c - 8'd1 : c;
   endfunction

   function automatic logic level_on();
      return level_cnt > on_level;
   endfunction

   function automatic logic vert_on();
      return vert_cnt > on_level;
   endfunction

   task automatic sample_position(input logic c1, input logic c2);
      level_cnt = saturate_step(level_cnt, c1);
      vert_cnt = saturate_step(vert_cnt, c2);
      if (left_side) begin
         if (level_on()) begin
            bolt = lms_pkg::POS_UNLOCK;
            if (door_en && track == lms_pkg::TRACK_IDLE) track = lms_pkg::TRACK_OPENLOCK;
         end else if (vert_on()) bolt = lms_pkg::POS_LOCK;
         else bolt = lms_pkg::POS_MID;
      end else begin
         if (level_on()) bolt = lms_pkg::POS_LOCK;
         else if (vert_on()) bolt = lms_pkg::POS_UNLOCK;
         else bolt = lms_pkg::POS_MID;
      end
   endtask

   // One process step of the bolt motor sequence in either direction.
   task automatic motor_step(input logic unlock, input logic c1, input logic c2,
                             input logic rev);
      logic fwd_one;
      logic hit;
      fwd_one = (unlock == left_side);
      case (step)
         lms_pkg::SS_IN: begin
            hit = fwd_one ? level_on() : vert_on();
            if (hit) step = lms_pkg::SS_OK;
            else begin
               drive = fwd_one ? lms_pkg::DRV_ONE : lms_pkg::DRV_ZERO;
               step = lms_pkg::SS_S1;
               step_tmr = lms_pkg::T_WORK;
               start_pulse = 1'b1;
            end
         end
         lms_pkg::SS_S1: begin
            if (step_tmr == 0) begin
               drive = lms_pkg::DRV_STOP; step = lms_pkg::SS_ERR;
            end else begin
               hit = fwd_one ? (level_on() || c1) : (vert_on() || c2);
               if (hit) begin
                  step = lms_pkg::SS_S2;
                  step_tmr = (!unlock && !left_side) ? 7'd2 : 7'd1;
               end
            end
         end
         lms_pkg::SS_S2: begin
            if (unlock) hit = left_side ? c1 : c2;
            else hit = c1 || c2;
            if (hit) step_tmr = '0;
            if (step_tmr == 0) begin
               drive = lms_pkg::DRV_STOP; step_tmr = lms_pkg::T_PAUSE; step = lms_pkg::SS_S3;
            end
         end
         lms_pkg::SS_S3: begin
            if (step_tmr == 0) begin
               travel_prev = rev;
               drive = fwd_one ? lms_pkg::DRV_ZERO : lms_pkg::DRV_ONE;
               step_tmr = lms_pkg::T_BACK;
               step = lms_pkg::SS_S4;
            end
         end
         lms_pkg::SS_S4: begin
            if (travel_prev != rev) step_tmr = '0;
            if (step_tmr == 0) begin
               step_tmr = lms_pkg::T_TRAVEL; step = lms_pkg::SS_S5;
            end
         end
         lms_pkg::SS_S5: begin
            if (!unlock) back_cnt = saturate_step(back_cnt, rev == 1'b0);
            if (step_tmr == 0) begin
               drive = lms_pkg::DRV_STOP; step = lms_pkg::SS_ERR;
            end else if (back_cnt < off_level || travel_prev != rev) begin
               step_tmr = '0; step = lms_pkg::SS_S6;
            end
         end
         lms_pkg::SS_S6: begin
            if (step_tmr == 0) begin
               drive = fwd_one ? lms_pkg::DRV_ZERO : lms_pkg::DRV_ONE;
               step = lms_pkg::SS_S7;
               if (unlock) step_tmr = left_side ? 7'd4 : 7'd6;
               else step_tmr = left_side ? 7'd5 : 7'd4;
            end
         end
         lms_pkg::SS_S7: begin
            if (step_tmr == 0) begin
               drive = lms_pkg::DRV_STOP; step = lms_pkg::SS_END;
            end
         end
         lms_pkg::SS_OK, lms_pkg::SS_END, lms_pkg::SS_ERR: ;
         default: begin
            drive = lms_pkg::DRV_STOP; step = lms_pkg::SS_ERR;
         end
      endcase
   endtask

   task automatic process_step(input logic [8:0] f);
      if (phase > 8'd0 && phase < 8'd4) begin
         sense_high = 1'b1;
         sample_position(f[3], f[4]);
      end
      case (mode)
         lms_pkg::MODE_IDLE: ;
         lms_pkg::MODE_LOCK: begin
            motor_step(1'b0, f[3], f[4], f[5]);
            if (step == lms_pkg::SS_OK) begin
               mode = lms_pkg::MODE_IDLE; done_code = lms_pkg::CMP_THERE;
            end else if (step == lms_pkg::SS_END) begin
               mode = lms_pkg::MODE_IDLE; done_code = lms_pkg::CMP_DONE;
            end else if (step == lms_pkg::SS_ERR) begin
               mode = lms_pkg::MODE_IDLE; done_code = lms_pkg::CMP_ERR;
            end
         end
         lms_pkg::MODE_UNLOCK: begin
            motor_step(1'b1, f[3], f[4], f[5]);
            if (step == lms_pkg::SS_OK) begin
               mode = lms_pkg::MODE_IDLE; done_code = lms_pkg::CMP_THERE;
               if (auto_en) auto_tmr = auto_ticks;
            end else if (step == lms_pkg::SS_ERR) begin
               mode = lms_pkg::MODE_IDLE; done_code = lms_pkg::CMP_ERR;
            end else if (step == lms_pkg::SS_END) begin
               done_code = lms_pkg::CMP_DONE; mode = lms_pkg::MODE_IDLE;
               if (!test_mode) begin
                  if (auto_en) auto_tmr = auto_ticks;
                  if (door_en) begin
                     step_tmr = lms_pkg::T_WORK; mode = lms_pkg::MODE_WAIT;
                  end
               end
            end
         end
         lms_pkg::MODE_WAIT: begin
            if (f[7]) begin
               track = lms_pkg::TRACK_OPEN; mode = lms_pkg::MODE_IDLE;
            end else if (step_tmr == 0) begin
               mode = lms_pkg::MODE_IDLE; track = lms_pkg::TRACK_OPENLOCK;
            end
         end
         default: mode = lms_pkg::MODE_IDLE;
      endcase
   endtask

   task automatic tick_step();
      if (step_tmr != 0) step_tmr = step_tmr - 7'd1;
      if (auto_tmr != 0) begin
         auto_tmr = auto_tmr - 8'd1;
         if (auto_tmr == 0) relock_pulse = 1'b1;
      end
      // While the motor runs the phase is parked at 2 so process steps keep sampling.
      if (phase == lms_pkg::PHASE_RESTART) begin
         sense_high = 1'b1;
         phase = phase + 8'd1;
      end else if (mode != lms_pkg::MODE_IDLE) begin
         sense_high = 1'b1;
         phase = 8'd2;
      end else begin
         if (phase == 8'd4) sense_high = 1'b0;
         else if (phase > 8'd8) phase = lms_pkg::PHASE_WRAP;
         phase = phase + 8'd1;
      end
   endtask

   task automatic door_step(input logic closed);
      if (closed) begin
         if (door_cnt < 2'd3) begin
            door_cnt = door_cnt + 2'd1;
            if (door_cnt == 2'd3 && track == lms_pkg::TRACK_OPEN && door_en
                && bolt != lms_pkg::POS_LOCK)
               relock_pulse = 1'b1;
         end
      end else if (door_cnt > 0) begin
         door_cnt = door_cnt - 2'd1;
         if (door_cnt == 0 && track == lms_pkg::TRACK_OPENLOCK) track = lms_pkg::TRACK_OPEN;
      end
   endtask

   // Applies one accepted request to the shadow state and returns the packed result.
   task automatic predict_result(input logic [8:0] f, output logic [11:0] r);
      done_code = lms_pkg::CMP_NONE; start_pulse = 1'b0; relock_pulse = 1'b0;
      case (f[2:0])
         lms_pkg::REQ_TICK: tick_step();
         lms_pkg::REQ_OPEN: begin
            if (mode == lms_pkg::MODE_IDLE) begin
               mode = lms_pkg::MODE_UNLOCK; step = lms_pkg::SS_IN; left_side = f[8];
            end
         end
         lms_pkg::REQ_CLOSE: begin
            if (mode == lms_pkg::MODE_IDLE || mode == lms_pkg::MODE_WAIT) begin
               mode = lms_pkg::MODE_LOCK; track = lms_pkg::TRACK_IDLE;
               step = lms_pkg::SS_IN; left_side = f[8];
            end
         end
         lms_pkg::REQ_PROC: process_step(f);
         lms_pkg::REQ_DOOR: door_step(f[6]);
         default: ;
      endcase
      r = {sense_high, track, relock_pulse, start_pulse, done_code,
           mode != lms_pkg::MODE_IDLE, bolt, drive};
   endtask

   // Sends one request, honoring the sender idle rate, and records its expected result.
   task automatic send_request(input logic [8:0] f);
      logic [11:0] r;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {7'd0, f};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_result(f, r);
      expected_results.push_back(r);
   endtask

   function automatic logic [8:0] make_request(logic [2:0] kind);
      logic [8:0] f;
      f = 9'($urandom());
      f[2:0] = kind;
      return f;
   endfunction

   // Blocks until every request has its result and the block has settled.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0 || rsp_tvalid) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [7:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         lms_pkg::CSR_ON_LEVEL:  on_level = value;
         lms_pkg::CSR_OFF_LEVEL: off_level = value;
         lms_pkg::CSR_CEILING:   ceiling_lvl = value;
         lms_pkg::CSR_FLOOR:     floor_lvl = value;
         lms_pkg::CSR_AUTO_EN:   auto_en = value[0];
         lms_pkg::CSR_DOOR_EN:   door_en = value[0];
         lms_pkg::CSR_AUTO_TICK: auto_ticks = value;
         lms_pkg::CSR_TEST_MODE: test_mode = value[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic write_all_csrs(input logic [7:0] on_l, input logic [7:0] off_l,
                                 input logic [7:0] ceil_l, input logic [7:0] flr_l,
                                 input logic [7:0] aen, input logic [7:0] den,
                                 input logic [7:0] aticks, input logic [7:0] tmode);
      wait_drained();
      write_csr(lms_pkg::CSR_ON_LEVEL, on_l);
      write_csr(lms_pkg::CSR_OFF_LEVEL, off_l);
      write_csr(lms_pkg::CSR_CEILING, ceil_l);
      write_csr(lms_pkg::CSR_FLOOR, flr_l);
      write_csr(lms_pkg::CSR_AUTO_EN, aen);
      write_csr(lms_pkg::CSR_DOOR_EN, den);
      write_csr(lms_pkg::CSR_AUTO_TICK, aticks);
      write_csr(lms_pkg::CSR_TEST_MODE, tmode);
   endtask

   // A command, then ticks, process steps, door scans and a rare further command or
   // reserved code, all with random switch levels; it walks the sequencer's sub steps.
   task automatic send_sequence(output int sent);
      int len;
      int pick;
      logic [8:0] f;
      send_request(make_request($urandom_range(0, 1) ? lms_pkg::REQ_OPEN
                                                     : lms_pkg::REQ_CLOSE));
      len = $urandom_range(20, 90);
      for (int i = 0; i < len; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) f = make_request(lms_pkg::REQ_TICK);
         else if (pick < 82) f = make_request(lms_pkg::REQ_PROC);
         else if (pick < 95) f = make_request(lms_pkg::REQ_DOOR);
         else if (pick < 98)
            f = make_request($urandom_range(0, 1) ? lms_pkg::REQ_OPEN : lms_pkg::REQ_CLOSE);
         else f = make_request(3'($urandom_range(5, 7)));
         send_request(f);
      end
      sent = len + 1;
   endtask

   task automatic send_random_mix(input int count);
      int sent;
      int done_items;
      done_items = 0;
      while (done_items < count) begin
         if ($urandom_range(0, 99) < 85) begin
            send_sequence(sent);
            done_items += sent;
         end else begin
            // Noise: any request type, reserved codes included.
            for (int i = 0; i < 5; i++) send_request(9'($urandom()));
            done_items += 5;
         end
      end
   endtask

   // Directed part: defaults after reset, every request type, commands while busy,
   // and a lock run taken far enough to drive the motor.
   task automatic test_directed();
      send_request(make_request(lms_pkg::REQ_TICK));
      for (int t = 5; t < 8; t++) send_request(make_request(t[2:0]));
      send_request(9'h000);
      send_request({6'h3f, lms_pkg::REQ_DOOR});
      send_request({6'h00, lms_pkg::REQ_DOOR});
      send_request({6'h3f, lms_pkg::REQ_PROC});
      send_request({6'h20, lms_pkg::REQ_CLOSE});
      // An open and a second close while locking are both ignored.
      send_request({6'h00, lms_pkg::REQ_OPEN});
      send_request({6'h00, lms_pkg::REQ_CLOSE});
      for (int i = 0; i < 6; i++) send_request({6'h03, lms_pkg::REQ_PROC});
      for (int i = 0; i < 4; i++) send_request(make_request(lms_pkg::REQ_TICK));
      for (int i = 0; i < 4; i++) send_request({6'h04, lms_pkg::REQ_PROC});
   endtask

   // Register extremes, including a floor above the ceiling and a zero auto-lock delay.
   task automatic test_register_extremes();
      write_all_csrs(8'd0, 8'd0, 8'd0, 8'd0, 8'h00, 8'h00, 8'd0, 8'h00);
      send_random_mix(60);
      write_all_csrs(8'd255, 8'd255, 8'd255, 8'd255, 8'hff, 8'hff, 8'd255, 8'hff);
      send_random_mix(60);
      write_all_csrs(8'd1, 8'd3, 8'd2, 8'd6, 8'h01, 8'h01, 8'd0, 8'h00);
      send_random_mix(60);
   endtask

   // One idling phase of the random part under a random, mostly reachable setting.
   task automatic test_random_phase(input int s_idle, input int r_stall, input int count);
      write_all_csrs(8'($urandom_range(0, 4)), 8'($urandom_range(1, 4)),
                     8'($urandom_range(3, 8)), 8'($urandom_range(0, 1)),
                     8'($urandom()), 8'($urandom()),
                     8'($urandom_range(0, 30)), 8'($urandom_range(0, 3) == 0));
      send_idle_pct = s_idle;
      recv_stall_pct = r_stall;
      send_random_mix(count);
   endtask

   // The receiver holds off for a long stretch while requests keep coming,
   // so the output register fills and the request side has to stall.
   task automatic test_backpressure();
      wait_drained();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      ->hold_go;
      send_random_mix(30);
   endtask

   // Long receiver hold, counted in cycles here.
   initial begin
      forever begin
         @(hold_go);
         hold_active <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         hold_active <= 1'b0;
      end
   end

   // Result checking and receiver pacing share one process so both see the same edge.
   always @(posedge clock) begin
      logic [11:0] exp_r;
      logic [11:0] act_r;
      if (rsp_tvalid && rsp_tready) begin
         act_r = rsp_tdata[11:0];
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result %h with nothing expected", $time, act_r);
            errors++;
         end else begin
            exp_r = expected_results.pop_front();
            if (exp_r[1:0] != act_r[1:0])
               $display("%0t: motor_drive expected %0d got %0d", $time, exp_r[1:0], act_r[1:0]);
            if (exp_r[3:2] != act_r[3:2])
               $display("%0t: position expected %0d got %0d", $time, exp_r[3:2], act_r[3:2]);
            if (exp_r[4] != act_r[4])
               $display("%0t: busy_res expected %0d got %0d", $time, exp_r[4], act_r[4]);
            if (exp_r[6:5] != act_r[6:5])
               $display("%0t: completion expected %0d got %0d", $time, exp_r[6:5], act_r[6:5]);
            if (exp_r[7] != act_r[7])
               $display("%0t: start_beep expected %0d got %0d", $time, exp_r[7], act_r[7]);
            if (exp_r[8] != act_r[8])
               $display("%0t: auto_lock_request expected %0d got %0d", $time, exp_r[8],
                        act_r[8]);
            if (exp_r[10:9] != act_r[10:9])
               $display("%0t: door_state expected %0d got %0d", $time, exp_r[10:9],
                        act_r[10:9]);
            if (exp_r[11] != act_r[11])
               $display("%0t: sense_drive_high expected %0d got %0d", $time, exp_r[11],
                        act_r[11]);
            if (exp_r != act_r) errors++;
         end
      end
      if (hold_active) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("** lock_motor_sequencer: FAILED **");
         $finish;
      end
   end

   initial begin
      model_reset();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_register_extremes();
      test_random_phase(0, 0, 270);
      test_random_phase(54, 0, 270);
      test_random_phase(0, 54, 270);
      test_random_phase(12, 12, 270);
      test_backpressure();
      wait_drained();
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("** lock_motor_sequencer: PASSED **");
      end else begin
         $display("** lock_motor_sequencer: FAILED **");
      end
      $finish;
   end
endmodule
